// ----- design/bap_pkg.sv -----
// Shared types, sizes and reciprocal tables for the block average pooling unit.
package bap_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_POOL   = 16;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 16;
    localparam int PIDX_W = $clog2(MAX_POOL);
    localparam int POOL_W = 5;
    localparam int DIM_W  = 11;

    // reciprocal scaling: floor(x/p) = (x * ceil(2^15/p)) >> 15 for x < 1024
    localparam int RCP_SHIFT  = 15;
    localparam int RCP_W      = 16;
    // floor(s/(p*p)) = (s * ceil(2^24/(p*p))) >> 24 for s < 65536
    localparam int ARCP_SHIFT = 24;
    localparam int ARCP_W     = 25;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_POOL_SIZE    = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef logic [2:0][SUM_W-1:0] t_sums;
    typedef logic [2:0][PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic [ROW_W-1:0] block_row;
        logic [COL_W-1:0] block_col;
        logic             frame_done;
    } t_blk_info;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_ADD  = 5'b01000,
        S_AVG  = 5'b10000
    } t_state;

    // ceil(2^15 / (idx+1))
    function automatic logic [RCP_W-1:0] pool_recip(input logic [PIDX_W-1:0] idx);
        logic [RCP_W-1:0] m;
        case (idx)
            4'd0:    m = 16'd32768;
            4'd1:    m = 16'd16384;
            4'd2:    m = 16'd10923;
            4'd3:    m = 16'd8192;
            4'd4:    m = 16'd6554;
            4'd5:    m = 16'd5462;
            4'd6:    m = 16'd4682;
            4'd7:    m = 16'd4096;
            4'd8:    m = 16'd3641;
            4'd9:    m = 16'd3277;
            4'd10:   m = 16'd2979;
            4'd11:   m = 16'd2731;
            4'd12:   m = 16'd2521;
            4'd13:   m = 16'd2341;
            4'd14:   m = 16'd2185;
            default: m = 16'd2048;
        endcase
        return m;
    endfunction

    // ceil(2^24 / (idx+1)^2)
    function automatic logic [ARCP_W-1:0] area_recip(input logic [PIDX_W-1:0] idx);
        logic [ARCP_W-1:0] m;
        case (idx)
            4'd0:    m = 25'd16777216;
            4'd1:    m = 25'd4194304;
            4'd2:    m = 25'd1864136;
            4'd3:    m = 25'd1048576;
            4'd4:    m = 25'd671089;
            4'd5:    m = 25'd466034;
            4'd6:    m = 25'd342393;
            4'd7:    m = 25'd262144;
            4'd8:    m = 25'd207127;
            4'd9:    m = 25'd167773;
            4'd10:   m = 25'd138655;
            4'd11:   m = 25'd116509;
            4'd12:   m = 25'd99274;
            4'd13:   m = 25'd85599;
            4'd14:   m = 25'd74566;
            default: m = 25'd65536;
        endcase
        return m;
    endfunction

endpackage

// ----- design/bap_avg_out.sv -----
// Block average divide by pool area and result output register.
module bap_avg_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  bap_pkg::t_blk_info         i_info,
    input  bap_pkg::t_sums             i_sums,
    input  logic [bap_pkg::PIDX_W-1:0] i_pool_idx,
    output logic                       o_free,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bap_pkg::ROW_W-1:0]  o_block_row,
    output logic [bap_pkg::COL_W-1:0]  o_block_col,
    output logic [bap_pkg::PIX_W-1:0]  o_avg0,
    output logic [bap_pkg::PIX_W-1:0]  o_avg1,
    output logic [bap_pkg::PIX_W-1:0]  o_avg2,
    output logic                       o_frame_done
);
    import bap_pkg::*;

    localparam int PROD_W = SUM_W + ARCP_W;

    logic                    r_valid;
    t_blk_info               r_info;
    t_pixel                  r_avg;
    logic [ARCP_W-1:0]       w_recip;
    logic [2:0][PROD_W-1:0]  w_prod;

    assign w_recip = area_recip(i_pool_idx);
    assign o_free  = !r_valid || i_out_ready;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_prod[c] = PROD_W'(i_sums[c]) * PROD_W'(w_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_info <= i_info;
            for (int c = 0; c < 3; c++) begin
                r_avg[c] <= w_prod[c][ARCP_SHIFT +: PIX_W];
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_block_row  = r_info.block_row;
    assign o_block_col  = r_info.block_col;
    assign o_frame_done = r_info.frame_done;
    assign o_avg0       = r_avg[0];
    assign o_avg1       = r_avg[1];
    assign o_avg2       = r_avg[2];

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_out_ready))
        else $error("result register overwritten while still pending");
`endif

endmodule

// ----- design/block_average_pooling_unit.sv -----
// Sequence: a pixel is taken in S_IDLE; S_DIV computes its block, S_READ reads the
// column sum and S_ADD writes the update. A block's last pixel then waits in S_AVG
// until the result register is free and loads it. A new pixel is taken only in S_IDLE;
// the single-port read-modify-write of the column sum memory sets this sequence.
// Reset: synchronous, active low; clears counters, handshakes and sets pool 8, 128x128.
// The sum memory is not cleared: the first pixel of each block overwrites its entry.
module block_average_pooling_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bap_pkg::APB_AW-1:0]  paddr,
    input  logic [bap_pkg::APB_DW-1:0]  pwdata,
    output logic [bap_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // pixel input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bap_pkg::PIX_W-1:0]   i_chan0,
    input  logic [bap_pkg::PIX_W-1:0]   i_chan1,
    input  logic [bap_pkg::PIX_W-1:0]   i_chan2,
    input  logic                        i_frame_start,
    // block output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bap_pkg::ROW_W-1:0]   o_block_row,
    output logic [bap_pkg::COL_W-1:0]   o_block_col,
    output logic [bap_pkg::PIX_W-1:0]   o_avg0,
    output logic [bap_pkg::PIX_W-1:0]   o_avg1,
    output logic [bap_pkg::PIX_W-1:0]   o_avg2,
    output logic                        o_frame_done
);
    import bap_pkg::*;

    localparam int CPROD_W = COL_W + RCP_W;
    localparam int RPROD_W = ROW_W + RCP_W;

    // configuration registers
    logic [POOL_W-1:0] r_pool_size;
    logic [DIM_W-1:0]  r_image_width;
    logic [DIM_W-1:0]  r_image_height;

    logic [POOL_W-1:0] w_pool;
    logic [DIM_W-1:0]  w_width;
    logic [DIM_W-1:0]  w_height;
    logic [PIDX_W-1:0] w_plast;
    logic [COL_W-1:0]  w_wlast;
    logic [ROW_W-1:0]  w_hlast;
    logic              w_cfg_wr;

    // control and datapath
    t_state            r_state;
    t_state            n_state;
    logic [COL_W-1:0]  r_pcol;
    logic [ROW_W-1:0]  r_prow;
    logic [PIDX_W-1:0] r_cib;
    logic [PIDX_W-1:0] r_rib;
    t_pixel            r_px;
    logic [COL_W-1:0]  r_blk;
    logic [ROW_W-1:0]  r_brow;
    t_sums             r_sum;
    t_sums             n_sum;
    logic              r_frame_end;
    logic              r_last;

    logic              w_in_acc;
    logic              w_first;
    logic              w_row_end;
    logic              w_frame_end;
    logic              w_last;
    logic              w_out_free;
    logic              w_load;
    logic [RCP_W-1:0]  w_recip;
    logic [CPROD_W-1:0] w_cprod;
    logic [RPROD_W-1:0] w_rprod;
    t_blk_info         w_info;

    // column sum memory
    t_sums             r_mem [MAX_WIDTH];
    t_sums             r_rd_data;
    logic              w_we;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size    <= POOL_W'(8);
            r_image_width  <= DIM_W'(128);
            r_image_height <= DIM_W'(128);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_POOL_SIZE:    r_pool_size    <= pwdata[POOL_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POOL_SIZE:    prdata = APB_DW'(r_pool_size);
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_image_height);
            default:          prdata = '0;
        endcase
    end

    // out-of-range sizes are pinned to the legal range
    always_comb begin
        if (r_pool_size == '0) begin
            w_pool = POOL_W'(1);
        end else if (r_pool_size > POOL_W'(MAX_POOL)) begin
            w_pool = POOL_W'(MAX_POOL);
        end else begin
            w_pool = r_pool_size;
        end
        if (r_image_width == '0) begin
            w_width = DIM_W'(1);
        end else if (r_image_width > DIM_W'(MAX_WIDTH)) begin
            w_width = DIM_W'(MAX_WIDTH);
        end else begin
            w_width = r_image_width;
        end
        if (r_image_height == '0) begin
            w_height = DIM_W'(1);
        end else if (r_image_height > DIM_W'(MAX_HEIGHT)) begin
            w_height = DIM_W'(MAX_HEIGHT);
        end else begin
            w_height = r_image_height;
        end
    end

    assign w_plast = PIDX_W'(w_pool - POOL_W'(1));
    assign w_wlast = COL_W'(w_width - DIM_W'(1));
    assign w_hlast = ROW_W'(w_height - DIM_W'(1));

    // ---------------- sequencer ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_first     = (r_cib == '0) && (r_rib == '0);
    assign w_row_end   = (r_pcol >= w_wlast);
    assign w_frame_end = w_row_end && (r_prow >= w_hlast);
    assign w_last      = (r_cib >= w_plast) && (r_rib >= w_plast);
    assign w_we        = (r_state == S_ADD);
    assign w_load      = (r_state == S_AVG) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_DIV;
            S_DIV:  n_state = S_READ;
            S_READ: n_state = S_ADD;
            S_ADD:  n_state = w_last ? S_AVG : S_IDLE;
            S_AVG:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // position counters; frame_start restarts them before the pixel is used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcol <= '0;
            r_prow <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
        end else if (w_in_acc && i_frame_start) begin
            r_pcol <= '0;
            r_prow <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
        end else if (w_we) begin
            if (w_row_end) begin
                r_pcol <= '0;
                r_cib  <= '0;
                if (w_frame_end) begin
                    r_prow <= '0;
                    r_rib  <= '0;
                end else begin
                    r_prow <= r_prow + ROW_W'(1);
                    r_rib  <= (r_rib >= w_plast) ? '0 : r_rib + PIDX_W'(1);
                end
            end else begin
                r_pcol <= r_pcol + COL_W'(1);
                r_cib  <= (r_cib >= w_plast) ? '0 : r_cib + PIDX_W'(1);
            end
        end
    end

    // block column and row by reciprocal multiply
    assign w_recip = pool_recip(w_plast);
    assign w_cprod = CPROD_W'(r_pcol) * CPROD_W'(w_recip);
    assign w_rprod = RPROD_W'(r_prow) * RPROD_W'(w_recip);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (w_first) begin
                n_sum[c] = SUM_W'(r_px[c]);
            end else begin
                n_sum[c] = r_rd_data[c] + SUM_W'(r_px[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px <= {i_chan2, i_chan1, i_chan0};
        end
        if (r_state == S_DIV) begin
            r_blk  <= w_cprod[RCP_SHIFT +: COL_W];
            r_brow <= w_rprod[RCP_SHIFT +: ROW_W];
        end
        if (w_we) begin
            r_sum       <= n_sum;
            r_frame_end <= w_frame_end;
            r_last      <= w_last;
        end
    end

    // single-port memory: read every cycle, write in the update cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_blk] <= n_sum;
        end
        r_rd_data <= r_mem[r_blk];
    end

    // ---------------- result ----------------
    assign w_info.block_row  = r_brow;
    assign w_info.block_col  = r_blk;
    assign w_info.frame_done = r_frame_end;

    bap_avg_out u_avg_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_info       (w_info),
        .i_sums       (r_sum),
        .i_pool_idx   (w_plast),
        .o_free       (w_out_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_block_row  (o_block_row),
        .o_block_col  (o_block_col),
        .o_avg0       (o_avg0),
        .o_avg1       (o_avg1),
        .o_avg2       (o_avg2),
        .o_frame_done (o_frame_done)
    );

`ifndef SYNTHESIS
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV))
        else $error("accepted transaction did not start block lookup");

    a_add_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_state) == S_READ))
        else $error("sum update without a memory read");

    a_blk_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |->
            ((15'(r_blk) * 15'(w_pool)) <= 15'(r_pcol)) &&
            (15'(r_pcol) < ((15'(r_blk) + 15'd1) * 15'(w_pool))))
        else $error("block column is not pixel column divided by pool size");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_AVG) && $past(r_last))
        else $error("result raised without a completed block");
`endif

endmodule
